// ===== sv/cau_pkg.sv =====
// shared operation codes for the complex arithmetic unit
package cau_pkg;

   typedef logic [1:0] func_type;

   localparam func_type FUNC_ADD = 2'd0;
   localparam func_type FUNC_SUB = 2'd1;
   localparam func_type FUNC_MUL = 2'd2;
   localparam func_type FUNC_DIV = 2'd3;

endpackage

// ===== sv/complex_arith_unit_top.sv =====
// complex add, subtract, multiply and divide in signed fixed point, fully pipelined
//
// One beat enters per clock: busy is always low, and start may be held high every
// cycle. Each beat gives exactly one result beat, marked by rsp_valid. The restoring
// divider takes one pipeline stage per quotient bit (DATA_WIDTH+1 of them) plus one
// stage that detects a quotient too large to fit. Every operation walks the same pipe,
// so results come out in order. The receiver cannot stall the result side and the
// pipe never waits on it. Parts are truncated toward zero after scaling and saturated
// to the output range, which raises rsp_overflow. A divide by zero gives both parts
// at the largest positive value with rsp_div_zero set.
module complex_arith_unit_top
   import cau_pkg::*;
#(
   parameter int DATA_WIDTH = 32,
   parameter int FRAC_BITS  = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic [1:0]                   req_func,
   input  logic signed [DATA_WIDTH-1:0] req_a_re,
   input  logic signed [DATA_WIDTH-1:0] req_a_im,
   input  logic signed [DATA_WIDTH-1:0] req_b_re,
   input  logic signed [DATA_WIDTH-1:0] req_b_im,
   output logic                         rsp_valid,
   output logic signed [DATA_WIDTH-1:0] rsp_res_re,
   output logic signed [DATA_WIDTH-1:0] rsp_res_im,
   output logic                         rsp_div_zero,
   output logic                         rsp_overflow
);

   localparam int W  = DATA_WIDTH;
   localparam int PW = 2 * W;                  // product width
   localparam int SW = PW + 1;                 // sum of two products
   localparam int XW = 3 * W + FRAC_BITS + 2;  // remainder width in the divider
   localparam int QW = W + 1;                  // quotient bits kept

   // divider pipe entry
   typedef struct packed {
      logic          vld;
      logic          div;
      logic          dz;
      logic          re_neg;
      logic          im_neg;
      logic          re_big;
      logic          im_big;
      logic [XW-1:0] re_rem;
      logic [XW-1:0] im_rem;
      logic [PW-1:0] den;
      logic [QW-1:0] re_q;
      logic [QW-1:0] im_q;
   } dstage_type;

   // never stalls
   assign busy = 1'b0;

   // stage 1: operand capture
   logic                 s1_vld_ff;
   func_type             s1_func_ff;
   logic signed [W-1:0]  s1_are_ff, s1_aim_ff, s1_bre_ff, s1_bim_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff <= start;
      end
      s1_func_ff <= req_func;
      s1_are_ff  <= req_a_re;
      s1_aim_ff  <= req_a_im;
      s1_bre_ff  <= req_b_re;
      s1_bim_ff  <= req_b_im;
   end

   // stage 2: six products and the plain sums or differences
   logic                 s2_vld_ff;
   func_type             s2_func_ff;
   logic signed [PW-1:0] s2_ac_ff, s2_bd_ff, s2_bc_ff, s2_ad_ff, s2_cc_ff, s2_dd_ff;
   logic signed [W:0]    s2_sre_ff, s2_sim_ff;
   logic signed [W:0]    s2_sre_in, s2_sim_in;

   always_comb begin
      if (s1_func_ff == FUNC_SUB) begin
         s2_sre_in = (W+1)'(s1_are_ff) - (W+1)'(s1_bre_ff);
         s2_sim_in = (W+1)'(s1_aim_ff) - (W+1)'(s1_bim_ff);
      end else begin
         s2_sre_in = (W+1)'(s1_are_ff) + (W+1)'(s1_bre_ff);
         s2_sim_in = (W+1)'(s1_aim_ff) + (W+1)'(s1_bim_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_vld_ff <= 1'b0;
      end else begin
         s2_vld_ff <= s1_vld_ff;
      end
      s2_func_ff <= s1_func_ff;
      s2_ac_ff   <= PW'(s1_are_ff) * PW'(s1_bre_ff);
      s2_bd_ff   <= PW'(s1_aim_ff) * PW'(s1_bim_ff);
      s2_bc_ff   <= PW'(s1_aim_ff) * PW'(s1_bre_ff);
      s2_ad_ff   <= PW'(s1_are_ff) * PW'(s1_bim_ff);
      s2_cc_ff   <= PW'(s1_bre_ff) * PW'(s1_bre_ff);
      s2_dd_ff   <= PW'(s1_bim_ff) * PW'(s1_bim_ff);
      s2_sre_ff  <= s2_sre_in;
      s2_sim_ff  <= s2_sim_in;
   end

   // stage 3: signed parts and squared divisor magnitude
   logic                 s3_vld_ff;
   func_type             s3_func_ff;
   logic signed [SW-1:0] s3_re_ff, s3_im_ff;
   logic signed [SW-1:0] s3_re_in, s3_im_in;
   logic [PW-1:0]        s3_den_ff;

   always_comb begin
      case (s2_func_ff)
         FUNC_MUL: begin
            s3_re_in = SW'(s2_ac_ff) - SW'(s2_bd_ff);
            s3_im_in = SW'(s2_bc_ff) + SW'(s2_ad_ff);
         end
         FUNC_DIV: begin
            s3_re_in = SW'(s2_ac_ff) + SW'(s2_bd_ff);
            s3_im_in = SW'(s2_bc_ff) - SW'(s2_ad_ff);
         end
         default: begin
            s3_re_in = SW'(s2_sre_ff);
            s3_im_in = SW'(s2_sim_ff);
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_vld_ff <= 1'b0;
      end else begin
         s3_vld_ff <= s2_vld_ff;
      end
      s3_func_ff <= s2_func_ff;
      s3_re_ff   <= s3_re_in;
      s3_im_ff   <= s3_im_in;
      s3_den_ff  <= unsigned'(s2_cc_ff) + unsigned'(s2_dd_ff);
   end

   // stage 4: magnitudes, fixed-point scaling, zero divisor
   logic [SW-1:0] re_mag, im_mag;
   logic [XW-1:0] re_scl, im_scl;

   dstage_type dv_ff [0:QW+1];
   dstage_type dv_in [0:QW+1];

   always_comb begin
      re_mag = s3_re_ff[SW-1] ? SW'(-s3_re_ff) : SW'(s3_re_ff);
      im_mag = s3_im_ff[SW-1] ? SW'(-s3_im_ff) : SW'(s3_im_ff);
      case (s3_func_ff)
         FUNC_MUL: begin
            re_scl = XW'(re_mag >> FRAC_BITS);
            im_scl = XW'(im_mag >> FRAC_BITS);
         end
         FUNC_DIV: begin
            re_scl = XW'(re_mag) << FRAC_BITS;
            im_scl = XW'(im_mag) << FRAC_BITS;
         end
         default: begin
            re_scl = XW'(re_mag);
            im_scl = XW'(im_mag);
         end
      endcase
      dv_in[0].vld    = s3_vld_ff;
      dv_in[0].div    = (s3_func_ff == FUNC_DIV);
      dv_in[0].dz     = (s3_func_ff == FUNC_DIV) && (s3_den_ff == '0);
      dv_in[0].re_neg = s3_re_ff[SW-1];
      dv_in[0].im_neg = s3_im_ff[SW-1];
      dv_in[0].re_big = 1'b0;
      dv_in[0].im_big = 1'b0;
      dv_in[0].re_rem = re_scl;
      dv_in[0].im_rem = im_scl;
      dv_in[0].den    = s3_den_ff;
      dv_in[0].re_q   = '0;
      dv_in[0].im_q   = '0;
   end

   // stage 5: quotient too wide to keep
   logic [XW-1:0] den_top;

   always_comb begin
      den_top = XW'(dv_ff[0].den) << QW;
      dv_in[1] = dv_ff[0];
      if (dv_ff[0].div) begin
         dv_in[1].re_big = (dv_ff[0].re_rem >= den_top);
         dv_in[1].im_big = (dv_ff[0].im_rem >= den_top);
      end
   end

   // one restoring step per quotient bit, most significant first
   for (genvar k = 2; k <= QW + 1; k++) begin : g_div
      localparam int Bit = QW + 1 - k;
      logic [XW-1:0] den_sh;
      always_comb begin
         den_sh = XW'(dv_ff[k-1].den) << Bit;
         dv_in[k] = dv_ff[k-1];
         if (dv_ff[k-1].div) begin
            if (dv_ff[k-1].re_rem >= den_sh) begin
               dv_in[k].re_rem    = dv_ff[k-1].re_rem - den_sh;
               dv_in[k].re_q[Bit] = 1'b1;
            end
            if (dv_ff[k-1].im_rem >= den_sh) begin
               dv_in[k].im_rem    = dv_ff[k-1].im_rem - den_sh;
               dv_in[k].im_q[Bit] = 1'b1;
            end
         end
      end
   end

   for (genvar k = 0; k <= QW + 1; k++) begin : g_pipe
      always_ff @(posedge clock) begin
         if (reset) begin
            dv_ff[k].vld <= 1'b0;
         end else begin
            dv_ff[k] <= dv_in[k];
         end
      end
   end

   // last stage: saturation and result beat
   localparam logic [XW-1:0] LimPos = XW'((64'd1 << (W - 1)) - 64'd1);
   localparam logic [XW-1:0] LimNeg = XW'(64'd1 << (W - 1));

   dstage_type    fin;
   logic [XW-1:0] re_fmag, im_fmag;
   logic          re_sat, im_sat;
   logic [W-1:0]  re_val, im_val;
   logic [W-1:0]  max_pos, max_neg;

   logic          rsp_valid_ff, rsp_div_zero_ff, rsp_overflow_ff;
   logic [W-1:0]  rsp_res_re_ff, rsp_res_im_ff;
   logic [W-1:0]  rsp_res_re_in, rsp_res_im_in;
   logic          rsp_overflow_in;

   always_comb begin
      fin     = dv_ff[QW+1];
      max_pos = W'(LimPos);
      max_neg = W'(LimNeg);
      re_fmag = fin.div ? XW'(fin.re_q) : fin.re_rem;
      im_fmag = fin.div ? XW'(fin.im_q) : fin.im_rem;
      re_sat  = fin.re_big || (re_fmag > (fin.re_neg ? LimNeg : LimPos));
      im_sat  = fin.im_big || (im_fmag > (fin.im_neg ? LimNeg : LimPos));
      re_val  = fin.re_neg ? W'(-re_fmag) : W'(re_fmag);
      im_val  = fin.im_neg ? W'(-im_fmag) : W'(im_fmag);
      if (fin.dz) begin
         rsp_res_re_in   = max_pos;
         rsp_res_im_in   = max_pos;
         rsp_overflow_in = 1'b0;
      end else begin
         rsp_res_re_in   = re_sat ? (fin.re_neg ? max_neg : max_pos) : re_val;
         rsp_res_im_in   = im_sat ? (fin.im_neg ? max_neg : max_pos) : im_val;
         rsp_overflow_in = re_sat || im_sat;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= fin.vld;
      end
      rsp_res_re_ff   <= rsp_res_re_in;
      rsp_res_im_ff   <= rsp_res_im_in;
      rsp_div_zero_ff <= fin.dz;
      rsp_overflow_ff <= rsp_overflow_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_res_re   = rsp_res_re_ff;
   assign rsp_res_im   = rsp_res_im_ff;
   assign rsp_div_zero = rsp_div_zero_ff;
   assign rsp_overflow = rsp_overflow_ff;

endmodule

// ===== sv/cau_checker.sv =====
// port-level checks for the complex arithmetic unit and their binding
module cau_checker
   import cau_pkg::*;
#(
   parameter int DATA_WIDTH = 32
) (
   input logic                  clock,
   input logic                  reset,
   input logic                  start,
   input logic                  busy,
   input logic [1:0]            req_func,
   input logic [DATA_WIDTH-1:0] req_b_re,
   input logic [DATA_WIDTH-1:0] req_b_im,
   input logic                  rsp_valid,
   input logic [DATA_WIDTH-1:0] rsp_res_re,
   input logic [DATA_WIDTH-1:0] rsp_res_im,
   input logic                  rsp_div_zero,
   input logic                  rsp_overflow
);

   localparam int Lat = DATA_WIDTH + 7;
   localparam logic [DATA_WIDTH-1:0] MaxPos = {1'b0, {(DATA_WIDTH-1){1'b1}}};
   localparam logic [DATA_WIDTH-1:0] MaxNeg = {1'b1, {(DATA_WIDTH-1){1'b0}}};

   // every accepted beat comes back after a fixed latency
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##Lat rsp_valid)
      else $error("result beat missing after accepted request");

   // a zero divisor is flagged on the matching result beat
   a_div_zero: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_func == FUNC_DIV && req_b_re == '0 && req_b_im == '0)
         |-> ##Lat (rsp_valid && rsp_div_zero))
      else $error("zero divisor not flagged");

   // zero divisor result is both parts at max positive, no overflow
   a_dz_value: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_div_zero)
         |-> (rsp_res_re == MaxPos && rsp_res_im == MaxPos && !rsp_overflow))
      else $error("bad zero divisor result");

   // overflow means at least one part sits on a rail
   a_ovf_rail: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_overflow)
         |-> (rsp_res_re == MaxPos || rsp_res_re == MaxNeg ||
              rsp_res_im == MaxPos || rsp_res_im == MaxNeg))
      else $error("overflow without saturated part");

endmodule

bind complex_arith_unit_top cau_checker #(.DATA_WIDTH(DATA_WIDTH)) u_cau_checker (.*);
